### rtl/core/assert_macros.svh
// Assertion macros shared by the scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/wbpm_pkg.sv
// Shared types and constants of the wildcard byte pattern matcher.
package wbpm_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int OFFSET_BITS_DEF = 32;

	localparam int DATA_BITS      = 8;
	localparam int PAT_REG_BITS   = 64;
	localparam int PAT_BYTES      = 16;
	localparam int PAT_IDX_BITS   = 4;
	localparam int WILD_BITS      = 16;
	localparam int LEN_BITS       = 5;
	localparam int MATCH_BITS     = 32;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 64;

	typedef logic [DATA_BITS-1:0]      byte_t;
	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
	typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;
	typedef logic [MATCH_BITS-1:0]     match_t;
	typedef logic [LEN_BITS-1:0]       len_t;

	// Configuration register indexes
	localparam cfg_index_t REG_PATTERN_LOW  = 2'd0;
	localparam cfg_index_t REG_PATTERN_HIGH = 2'd1;
	localparam cfg_index_t REG_WILDCARD     = 2'd2;
	localparam cfg_index_t REG_LENGTH       = 2'd3;

endpackage

### rtl/core/wbpm_if.sv
// Handshake channels of the matcher: byte stream, match results, register writes.
interface wbpm_in_if import wbpm_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  region_start;

	modport source (output valid, data_byte, region_start, input ready);
	modport sink (input valid, data_byte, region_start, output ready);
endinterface

interface wbpm_out_if import wbpm_pkg::*; ();
	logic   valid;
	logic   ready;
	match_t match_offset;

	modport source (output valid, match_offset, input ready);
	modport sink (input valid, match_offset, output ready);
endinterface

interface wbpm_cfg_if import wbpm_pkg::*; ();
	logic       valid;
	logic       ready;
	cfg_index_t reg_index;
	cfg_data_t  wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink (input valid, reg_index, wr_data, output ready);
endinterface

### rtl/core/wildcard_byte_pattern_matcher.sv
// Top level of the wildcard byte pattern matcher.
// Scans a byte stream one beat per cycle and reports, for every position where the last
// pattern_length bytes of the current region equal the configured pattern (wildcard bytes
// match anything), the region offset of the first matched byte; matches may overlap and a
// beat with region_start set restarts the window and the offset at zero. Throughput is one
// byte per clock when not stalled, set by the shift window and the parallel compare of all
// window entries, which fit between the window register and the result register. The
// stream stalls only while a result waits in the output register and the next byte in the
// window also matches. Registers are written over the cfg channel, which is always ready;
// the user must write them only while idle, which the block itself does not enforce.
`include "assert_macros.svh"

module wildcard_byte_pattern_matcher import wbpm_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	wbpm_in_if.sink    stream,
	wbpm_out_if.source result,
	wbpm_cfg_if.sink   cfg
);

	localparam int SEEN_BITS = $clog2(MAX_PATTERN + 1);

	// Configuration registers
	logic [PAT_REG_BITS-1:0] pat_low_q;
	logic [PAT_REG_BITS-1:0] pat_high_q;
	logic [WILD_BITS-1:0]    wild_q;
	len_t                    len_q;

	// Window state and first stage
	byte_t                  window_q [MAX_PATTERN];
	logic [SEEN_BITS-1:0]   seen_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [OFFSET_BITS-1:0] cur_s1;
	logic                   s1_valid_q;

	// Result register
	logic   out_valid_q;
	match_t match_offset_q;

	// Compare and handshake
	byte_t                  pat_bytes [PAT_BYTES];
	len_t                   len_sat;
	logic                   hit;
	logic [OFFSET_BITS-1:0] start_offset;
	logic                   s1_adv;
	logic                   accept;

	// Register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			wild_q     <= '0;
			len_q      <= LEN_BITS'(1);
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				REG_PATTERN_LOW:  pat_low_q  <= cfg.wr_data;
				REG_PATTERN_HIGH: pat_high_q <= cfg.wr_data;
				REG_WILDCARD:     wild_q     <= cfg.wr_data[WILD_BITS-1:0];
				REG_LENGTH:       len_q      <= cfg.wr_data[LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Split the pattern registers into bytes
	always_comb begin
		for (int k = 0; k < PAT_BYTES / 2; k++) begin
			pat_bytes[k]                 = pat_low_q[k*DATA_BITS +: DATA_BITS];
			pat_bytes[k + PAT_BYTES / 2] = pat_high_q[k*DATA_BITS +: DATA_BITS];
		end
	end

	// Saturate the length at the window depth
	assign len_sat = (len_q > LEN_BITS'(MAX_PATTERN)) ? LEN_BITS'(MAX_PATTERN) : len_q;

	// Compare every window entry in use with its pattern byte; entry 0 is the newest
	// byte and lines up with the last pattern byte
	always_comb begin
		len_t pidx;
		logic all_ok;
		pidx   = '0;
		all_ok = 1'b1;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			if (LEN_BITS'(j) < len_sat) begin
				pidx = len_sat - LEN_BITS'(j) - LEN_BITS'(1);
				if (!wild_q[pidx[PAT_IDX_BITS-1:0]] &&
				    window_q[j] != pat_bytes[pidx[PAT_IDX_BITS-1:0]]) begin
					all_ok = 1'b0;
				end
			end
		end
		hit = s1_valid_q && all_ok && (len_sat != '0) && (LEN_BITS'(seen_q) >= len_sat);
	end

	assign start_offset = cur_s1 - OFFSET_BITS'(len_sat - LEN_BITS'(1));

	// Handshake: the first stage drains unless a match is blocked by a full result register
	assign s1_adv       = s1_valid_q && (!hit || !out_valid_q || result.ready);
	assign stream.ready = !s1_valid_q || s1_adv;
	assign accept       = stream.valid && stream.ready;

	// Shift the window, count bytes and advance the offset on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_PATTERN; j++) begin
				window_q[j] <= '0;
			end
			seen_q     <= '0;
			offset_q   <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				window_q[0] <= stream.data_byte;
				for (int j = 1; j < MAX_PATTERN; j++) begin
					window_q[j] <= stream.region_start ? '0 : window_q[j-1];
				end
				if (stream.region_start) begin
					seen_q   <= SEEN_BITS'(1);
					offset_q <= OFFSET_BITS'(1);
				end else begin
					if (seen_q < SEEN_BITS'(MAX_PATTERN)) begin
						seen_q <= seen_q + SEEN_BITS'(1);
					end
					offset_q <= offset_q + OFFSET_BITS'(1);
				end
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// Hold the offset of the accepted byte for the compare stage
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1 <= stream.region_start ? '0 : offset_q;
		end
	end

	// Result register: load on a match, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && hit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && hit) begin
			match_offset_q <= MATCH_BITS'(start_offset);
		end
	end

	assign result.valid        = out_valid_q;
	assign result.match_offset = match_offset_q;

	// Checks
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, !stream.ready, s1_valid_q && out_valid_q && !result.ready)
	`ASSERT_NEXT(a_region_restart, clk, arst_n, accept && stream.region_start, seen_q == SEEN_BITS'(1) && cur_s1 == '0)
	`ASSERT_IMPLIES(a_seen_bound, clk, arst_n, 1'b1, seen_q <= SEEN_BITS'(MAX_PATTERN))
	`ASSERT_NEXT(a_result_source, clk, arst_n, !out_valid_q && !(s1_adv && hit), !out_valid_q)

endmodule

### tb/sv/wildcard_byte_pattern_matcher_tb.sv
// Self-checking testbench of the wildcard byte pattern matcher: directed and random byte streams.
`timescale 1ns / 100ps

module wildcard_byte_pattern_matcher_tb;
	import wbpm_pkg::*;

	localparam int IDLE_PCT     = 11;
	localparam int SETTLE_LAT   = 8;
	localparam int QUIET_LIMIT  = 5000;
	localparam int HOLD_OFF_LEN = 300;
	localparam int SCAN_PHASES  = 18;
	localparam int PHASE_BYTES  = 100;

	logic clk;
	logic arst_n;

	wbpm_in_if  in_if();
	wbpm_out_if out_if();
	wbpm_cfg_if cfg_if();

	wildcard_byte_pattern_matcher u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (in_if),
		.result (out_if),
		.cfg    (cfg_if)
	);

	// Shadow copy of the pattern registers
	logic [63:0] pat_lo;
	logic [63:0] pat_hi;
	logic [15:0] wild_mask;
	len_t        pat_len;

	// Shadow copy of the scan state
	byte_t       window [PAT_BYTES];
	match_t      region_off;
	int unsigned seen;

	match_t expected_offsets [$];
	int     mismatches;
	int     hold_left;
	bit     tx_steady;
	bit     rx_steady;
	int     quiet_cycles;

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic byte_t pattern_byte(int unsigned k);
		logic [127:0] both;
		both = {pat_hi, pat_lo};
		return both[8*k +: 8];
	endfunction

	// Shift one accepted byte into the window and queue the match offset it completes
	function automatic void scan_byte(byte_t value, logic first);
		int unsigned span;
		logic        hit;
		match_t      start_off;
		if (first) begin
			window = '{default: '0};
			region_off = '0;
			seen = 0;
		end
		for (int k = PAT_BYTES - 1; k > 0; k--)
			window[k] = window[k-1];
		window[0] = value;
		if (seen < PAT_BYTES)
			seen++;
		start_off = region_off;
		region_off = region_off + 1'b1;
		span = (pat_len > PAT_BYTES) ? PAT_BYTES : pat_len;
		if (span == 0 || seen < span)
			return;
		hit = 1'b1;
		for (int k = 0; k < span; k++)
			if (!wild_mask[k] && window[span-1-k] != pattern_byte(k))
				hit = 1'b0;
		if (hit)
			expected_offsets = {expected_offsets, start_off - match_t'(span - 1)};
	endfunction

	// Offer one byte, idling at random first, and predict once the beat is taken
	task automatic send_byte(byte_t value, logic first);
		@(negedge clk);
		while (!tx_steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_if.valid <= 1'b0;
			@(negedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.data_byte <= value;
		in_if.region_start <= first;
		do @(posedge clk); while (!in_if.ready);
		scan_byte(value, first);
	endtask

	// Drop valid, wait for every pending match, then let the pipeline settle
	task automatic wait_idle();
		@(negedge clk);
		in_if.valid <= 1'b0;
		while (expected_offsets.size() != 0)
			@(posedge clk);
		repeat (SETTLE_LAT) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, cfg_data_t value);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.reg_index <= idx;
		cfg_if.wr_data <= value;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			REG_PATTERN_LOW:  pat_lo = value;
			REG_PATTERN_HIGH: pat_hi = value;
			REG_WILDCARD:     wild_mask = value[WILD_BITS-1:0];
			REG_LENGTH:       pat_len = value[LEN_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic load_pattern(logic [63:0] lo, logic [63:0] hi, logic [15:0] wild, len_t len);
		wait_idle();
		write_reg(REG_PATTERN_LOW, lo);
		write_reg(REG_PATTERN_HIGH, hi);
		write_reg(REG_WILDCARD, cfg_data_t'(wild));
		write_reg(REG_LENGTH, cfg_data_t'(len));
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Reset values: pattern byte zero, length one, stream is one region from offset zero
	task automatic test_reset_state();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
	endtask

	// Overlapping matches, ignored bits above the length, short region after a restart
	task automatic test_overlap_and_regions();
		load_pattern(64'hFFFF_FFFF_FFAA_00AA, '1, 16'hFFFA, len_t'(3));
		send_byte(8'hAA, 1'b1);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'hAA, 1'b1);
		send_byte(8'hAA, 1'b0);
		send_byte(8'hAA, 1'b0);
	endtask

	// Length above the maximum saturates; length zero never matches
	task automatic test_long_and_zero_length();
		load_pattern('0, 64'hFF00_0000_0000_0000, 16'h7FFE, len_t'(17));
		send_byte(8'h00, 1'b1);
		repeat (14) send_byte(byte_t'($urandom_range(0, 255)), 1'b0);
		send_byte(8'hFF, 1'b0);
		load_pattern('0, '0, '0, len_t'(0));
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
	endtask

	// Hold off the result side while every byte matches, so the input stalls
	task automatic test_backpressure();
		load_pattern('0, '0, 16'hFFFF, len_t'(1));
		@(posedge clk);
		hold_left = HOLD_OFF_LEN;
		for (int i = 0; i < 40; i++)
			send_byte(byte_t'($urandom_range(0, 255)), (i == 0));
		wait_idle();
	endtask

	// Random patterns and streams built mostly from planted, lightly corrupted patterns
	task automatic test_random_scan();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [15:0] wild;
		len_t        len;
		int unsigned span;
		int          sent;
		int          pick;
		byte_t       value;
		for (int p = 0; p < SCAN_PHASES; p++) begin
			lo = {$urandom, $urandom};
			hi = {$urandom, $urandom};
			wild = 16'($urandom & $urandom);
			case ($urandom_range(0, 9))
				0: len = len_t'(16);
				1: len = len_t'($urandom_range(17, 31));
				2: len = '0;
				default: len = len_t'($urandom_range(1, 8));
			endcase
			if ($urandom_range(0, 7) == 0)
				wild = '1;
			case (p)
				0: begin
					lo = '1;
					hi = '1;
					wild = '0;
					len = len_t'(16);
				end
				1: begin
					lo = '0;
					hi = '0;
					len = '1;
				end
				2: len = len_t'(1);
				default: ;
			endcase
			load_pattern(lo, hi, wild, len);
			tx_steady = (p == 6 || p == 7);
			rx_steady = (p == 6 || p == 7);
			span = (len > PAT_BYTES) ? PAT_BYTES : len;
			if (span == 0)
				span = 4;
			sent = 0;
			while (sent < PHASE_BYTES) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					// plant a whole pattern with random wildcard bytes
					for (int k = 0; k < span; k++) begin
						value = wild_mask[k] ? byte_t'($urandom_range(0, 255)) : pattern_byte(k);
						if ($urandom_range(0, 7) == 0)
							value ^= byte_t'(1 << $urandom_range(0, 7));
						send_byte(value, (k == 0) && ($urandom_range(0, 9) == 0));
						sent++;
					end
				end else if (pick < 85) begin
					send_byte(pattern_byte($urandom_range(0, PAT_BYTES - 1)),
						$urandom_range(0, 99) < 3);
					sent++;
				end else begin
					send_byte(byte_t'($urandom_range(0, 255)), $urandom_range(0, 99) < 5);
					sent++;
				end
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// Result side: random idling, steady stretches and a counted hold-off
	initial begin
		out_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_if.ready <= 1'b0;
				hold_left--;
			end else if (rx_steady) begin
				out_if.ready <= 1'b1;
			end else begin
				out_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Compare each result beat with the oldest pending offset
	always @(posedge clk) begin
		match_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (expected_offsets.size() == 0) begin
				$error("match_offset: expected none, got %0d", out_if.match_offset);
				mismatches++;
			end else begin
				want = expected_offsets.pop_front();
				if (out_if.match_offset !== want) begin
					$error("match_offset: expected %0d, got %0d", want, out_if.match_offset);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.data_byte = '0;
		in_if.region_start = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.reg_index = REG_PATTERN_LOW;
		cfg_if.wr_data = '0;
		pat_lo = '0;
		pat_hi = '0;
		wild_mask = '0;
		pat_len = len_t'(1);
		window = '{default: '0};
		region_off = '0;
		seen = 0;
		mismatches = 0;
		hold_left = 0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		quiet_cycles = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_overlap_and_regions();
		test_long_and_zero_length();
		test_backpressure();
		test_random_scan();
		wait_idle();

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/wbpm_pkg.sv
rtl/core/wbpm_if.sv
rtl/core/wildcard_byte_pattern_matcher.sv
tb/sv/wildcard_byte_pattern_matcher_tb.sv
